[sv/cpr_pkg.sv]
package cpr_pkg;
    localparam int MAX_SLOTS = 8;
    localparam int PAGE_BITS = 16;
    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);

    localparam logic CFG_ALGORITHM_MODE = 1'b0;
    localparam logic CFG_FRAMES_IN_USE = 1'b1;
    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef struct packed {
        logic occupied;
        logic used;
        logic modified;
        logic [PAGE_BITS-1:0] page;
    } slot_entry_t;
endpackage

[sv/cpr_slot_ram.sv]
module cpr_slot_ram
    import cpr_pkg::*;
(
    input  logic                clk,
    input  logic                we,
    input  logic [SLOT_W-1:0]   waddr,
    input  slot_entry_t         wdata,
    input  logic [SLOT_W-1:0]   raddr,
    output slot_entry_t         rdata
);
    slot_entry_t mem [MAX_SLOTS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[sv/clock_page_replacement.sv]
// A release frees every slot; an access searches the n active slots in order and on a miss
// fills the first free slot, else sweeps from the hand to evict (clock or clock-M).
// Throughput: one item at a time; the next item is taken only after the result is
// accepted, and the slot memory is read one slot per cycle.
// Reset: all slots free, hand zero, algorithm_mode 0, frames_in_use 8. Status flags
// live in flip-flops and clear at once; page numbers live in the memory, no clear pass.
module clock_page_replacement
    import cpr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [15:0] page,
    input  logic        is_write,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        hit,
    output logic        fault,
    output logic [5:0]  slot,
    output logic        evicted,
    output logic [15:0] evicted_page,
    output logic        write_back
);
    typedef enum logic [2:0] {S_IDLE, S_SEARCH, S_SWEEP, S_EVICT, S_OUT} state_t;

    state_t state_reg;
    logic mode_reg;
    logic [6:0] frames_reg;
    // Flags in flip-flops; page numbers in memory.
    logic [MAX_SLOTS-1:0] occ_reg, used_reg, mod_reg;
    logic [SLOT_W-1:0] hand_reg, idx_reg, free_reg, vict_reg;
    logic free_found_reg;
    logic [1:0] pass_reg;     // clock-M sweep number 0..3
    logic [CNT_W-1:0] cnt_reg;
    logic [PAGE_BITS-1:0] page_reg;
    logic wr_reg;

    logic [CNT_W-1:0] n;
    logic [SLOT_W-1:0] last;
    slot_entry_t rdata, wdata;
    logic we;
    logic [SLOT_W-1:0] waddr, raddr;
    logic rvalid_reg;
    logic [SLOT_W-1:0] ridx_reg;

    always_comb
    begin
        if (frames_reg == 7'd0)
            n = CNT_W'(1);
        else if (frames_reg > 7'(MAX_SLOTS))
            n = CNT_W'(MAX_SLOTS);
        else
            n = frames_reg[CNT_W-1:0];
        last = SLOT_W'(n - CNT_W'(1));
    end

    assign cfg_ready = (state_reg == S_IDLE);
    assign in_ready = (state_reg == S_IDLE) && !out_valid;

    // Read the page of the slot under inspection; the data arrives in the next cycle.
    assign raddr = idx_reg;
    assign wdata = '{occupied: 1'b1, used: 1'b1, modified: wr_reg, page: page_reg};
    cpr_slot_ram u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    logic sweep_take;
    always_comb
    begin
        sweep_take = 1'b0;
        if (!mode_reg)
            sweep_take = !used_reg[idx_reg];
        else if (!pass_reg[0])
            sweep_take = !used_reg[idx_reg] && !mod_reg[idx_reg];
        else
            sweep_take = !used_reg[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg <= 1'b0;
            frames_reg <= 7'd8;
            occ_reg <= '0;
            used_reg <= '0;
            mod_reg <= '0;
            hand_reg <= '0;
            idx_reg <= '0;
            free_reg <= '0;
            vict_reg <= '0;
            free_found_reg <= 1'b0;
            pass_reg <= '0;
            cnt_reg <= '0;
            rvalid_reg <= 1'b0;
            ridx_reg <= '0;
            out_valid <= 1'b0;
            hit <= 1'b0;
            fault <= 1'b0;
            slot <= '0;
            evicted <= 1'b0;
            evicted_page <= '0;
            write_back <= 1'b0;
            page_reg <= '0;
            wr_reg <= 1'b0;
            we <= 1'b0;
            waddr <= '0;
        end
        else
        begin
            we <= 1'b0;
            rvalid_reg <= 1'b0;
            if (out_valid && out_ready)
                out_valid <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        if (cfg_index == CFG_ALGORITHM_MODE)
                            mode_reg <= cfg_data[0];
                        else
                            frames_reg <= cfg_data;
                    end
                    if (in_valid && in_ready)
                    begin
                        hit <= 1'b0; fault <= 1'b0; slot <= '0;
                        evicted <= 1'b0; evicted_page <= '0; write_back <= 1'b0;
                        page_reg <= page[PAGE_BITS-1:0];
                        wr_reg <= is_write;
                        if (operation == OP_RELEASE)
                        begin
                            occ_reg <= '0; used_reg <= '0; mod_reg <= '0;
                            out_valid <= 1'b1;
                        end
                        else
                        begin
                            idx_reg <= '0;
                            cnt_reg <= '0;
                            free_found_reg <= 1'b0;
                            state_reg <= S_SEARCH;
                        end
                    end
                end
                S_SEARCH:
                begin
                    // Issue one read per cycle; compare the returned entry.
                    if (cnt_reg < n)
                    begin
                        rvalid_reg <= 1'b1;
                        ridx_reg <= idx_reg;
                        idx_reg <= idx_reg + SLOT_W'(1);
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                    if (rvalid_reg)
                    begin
                        if (occ_reg[ridx_reg] && rdata.page == page_reg)
                        begin
                            used_reg[ridx_reg] <= 1'b1;
                            if (wr_reg) mod_reg[ridx_reg] <= 1'b1;
                            hit <= 1'b1;
                            slot <= 6'(ridx_reg);
                            out_valid <= 1'b1;
                            rvalid_reg <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                        else if (!occ_reg[ridx_reg] && !free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            free_reg <= ridx_reg;
                        end
                    end
                    if (cnt_reg == n && !rvalid_reg)
                    begin
                        fault <= 1'b1;
                        if (free_found_reg)
                        begin
                            we <= 1'b1;
                            waddr <= free_reg;
                            occ_reg[free_reg] <= 1'b1;
                            used_reg[free_reg] <= 1'b1;
                            mod_reg[free_reg] <= wr_reg;
                            slot <= 6'(free_reg);
                            out_valid <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg <= (CNT_W'(hand_reg) < n) ? hand_reg : '0;
                            cnt_reg <= '0;
                            pass_reg <= '0;
                            state_reg <= S_SWEEP;
                        end
                    end
                end
                S_SWEEP:
                begin
                    // Inspect one slot at the hand per cycle.
                    idx_reg <= (idx_reg == last) ? '0 : idx_reg + SLOT_W'(1);
                    if (sweep_take)
                    begin
                        vict_reg <= idx_reg;
                        hand_reg <= (idx_reg == last) ? '0 : idx_reg + SLOT_W'(1);
                        state_reg <= S_EVICT;
                    end
                    else
                    begin
                        if (!mode_reg || pass_reg[0])
                            used_reg[idx_reg] <= 1'b0;
                        if (cnt_reg == n - CNT_W'(1))
                        begin
                            cnt_reg <= '0;
                            pass_reg <= pass_reg + 2'd1;
                        end
                        else
                            cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                S_EVICT:
                begin
                    // Memory data for the victim is valid now (the read issued from S_SWEEP was the
                    // victim address); issue read then capture in S_OUT.
                    idx_reg <= vict_reg;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!rvalid_reg && idx_reg == vict_reg && cnt_reg != '1)
                    begin
                        rvalid_reg <= 1'b1;
                        cnt_reg <= '1;
                    end
                    if (rvalid_reg)
                    begin
                        evicted <= 1'b1;
                        evicted_page <= 16'(rdata.page);
                        write_back <= mod_reg[vict_reg];
                        we <= 1'b1;
                        waddr <= vict_reg;
                        used_reg[vict_reg] <= 1'b1;
                        mod_reg[vict_reg] <= wr_reg;
                        slot <= 6'(vict_reg);
                        out_valid <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit && fault)) else $error("hit and fault together");
    a_evict_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && evicted) |-> fault) else $error("eviction without fault");
    a_hand_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP) |-> (CNT_W'(idx_reg) < n)) else $error("hand outside slots");
endmodule
